// File: rtl/core/nrr_pkg.sv
// Shared constants, codes and types of the NACK retransmit responder.
package nrr_pkg;

    localparam int INDEX_BITS = 10;
    localparam int SEQ_BITS   = 16;
    localparam int TAG_BITS   = SEQ_BITS - INDEX_BITS;
    localparam int TAG_W      = (TAG_BITS > 0) ? TAG_BITS : 1;
    localparam int TIME_BITS  = 32;
    localparam int CNT_BITS   = 8;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SPAN       = 17;
    localparam int OFS_BITS   = 5;
    localparam int RTT_SHIFT  = 2;

    localparam logic [CFG_BITS-1:0] DEFAULT_RTT_MS       = 16'd10;
    localparam logic [CFG_BITS-1:0] DEFAULT_MAX_DELAY_MS = 16'd3000;

    localparam logic [CFG_IDX_W-1:0] CFG_RTT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 2'd1;

    localparam logic [1:0] ACT_RESEND = 2'd0;
    localparam logic [1:0] ACT_LOST   = 2'd1;
    localparam logic [1:0] ACT_SOON   = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    typedef struct packed {
        logic                 valid;
        logic [TAG_W-1:0]     tag;
        logic [TIME_BITS-1:0] sent;
        logic [CNT_BITS-1:0]  resends;
        logic [SEQ_BITS-1:0]  ext;
        logic [SEQ_BITS-1:0]  size;
    } entry_t;

    typedef struct packed {
        logic                  en;
        logic [INDEX_BITS-1:0] addr;
        entry_t                data;
    } wr_t;

    typedef struct packed {
        logic [1:0]          action;
        logic [SEQ_BITS-1:0] seq;
        logic [SEQ_BITS-1:0] ext;
        logic [SEQ_BITS-1:0] bytes;
        logic [CNT_BITS-1:0] count;
        logic                last;
    } result_t;

endpackage

// File: rtl/core/nrr_table.sv
// Packet entry memory: one write port, one registered read port.
module nrr_table (
    input  logic                          clk,
    input  nrr_pkg::wr_t                  wr,
    input  logic                          rd_en,
    input  logic [nrr_pkg::INDEX_BITS-1:0] rd_addr,
    output nrr_pkg::entry_t               rd_data
);
    import nrr_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/nrr_walk.sv
// Request sequencer: table clear, packet store and NACK walk with read-modify-write.
module nrr_walk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic                           mode,
    input  logic [15:0]                    seq,
    input  logic [15:0]                    lost_mask,
    input  logic [15:0]                    ext_seq,
    input  logic [15:0]                    packet_size,
    input  logic [31:0]                    now_ms,
    input  logic [nrr_pkg::CFG_BITS-1:0]   rtt,
    input  logic [nrr_pkg::CFG_BITS-1:0]   max_delay,
    input  logic                           out_free,
    output logic                           push,
    output nrr_pkg::result_t               push_res,
    output nrr_pkg::wr_t                   wr,
    output logic                           rd_en,
    output logic [nrr_pkg::INDEX_BITS-1:0] rd_addr,
    input  nrr_pkg::entry_t                rd_data
);
    import nrr_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;

    logic [2:0]            state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_reg, clr_next;
    logic [TIME_BITS-1:0]  latest_reg, latest_next;
    logic [SEQ_BITS-1:0]   base_reg, base_next;
    logic [SPAN-1:0]       pending_reg, pending_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [SEQ_BITS-1:0]   cur_reg, cur_next;
    logic                  held_vld_reg, held_vld_next;
    result_t               held_reg, held_next;

    logic [OFS_BITS-1:0]   ofs;
    logic [SEQ_BITS-1:0]   cur;
    logic [TIME_BITS-1:0]  delta;
    logic [CFG_BITS-1:0]   rtt_eff;
    logic [TIME_BITS-1:0]  soon;
    logic [TIME_BITS-1:0]  age_latest;
    logic [TIME_BITS-1:0]  age_now;
    logic                  hit;
    logic                  is_lost;
    logic                  is_soon;
    logic [CNT_BITS-1:0]   cnt_inc;
    result_t               found;

    always_comb
    begin
        ofs = '0;
        for (int k = SPAN - 1; k >= 0; k--)
        begin
            if (pending_reg[k])
            begin
                ofs = OFS_BITS'(k);
            end
        end
    end

    assign cur        = base_reg + SEQ_BITS'(ofs);
    assign delta      = now_ms - latest_reg;
    assign rtt_eff    = (rtt == '0) ? DEFAULT_RTT_MS : rtt;
    assign soon       = TIME_BITS'(rtt_eff >> RTT_SHIFT);
    assign age_latest = latest_reg - rd_data.sent;
    assign age_now    = now_reg - rd_data.sent;
    assign hit        = rd_data.valid && (rd_data.tag == TAG_W'(cur_reg >> INDEX_BITS));
    assign is_lost    = age_latest > TIME_BITS'(max_delay);
    assign is_soon    = age_now <= soon;
    assign cnt_inc    = (rd_data.resends == '1) ? rd_data.resends : rd_data.resends + 1'b1;

    always_comb
    begin
        found.seq   = cur_reg;
        found.ext   = rd_data.ext;
        found.bytes = rd_data.size;
        found.last  = 1'b0;
        if (is_lost)
        begin
            found.action = ACT_LOST;
            found.count  = rd_data.resends;
        end
        else if (is_soon)
        begin
            found.action = ACT_SOON;
            found.count  = rd_data.resends;
        end
        else
        begin
            found.action = ACT_RESEND;
            found.count  = cnt_inc;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        latest_next   = latest_reg;
        base_next     = base_reg;
        pending_next  = pending_reg;
        now_next      = now_reg;
        cur_next      = cur_reg;
        held_vld_next = held_vld_reg;
        held_next     = held_reg;
        item_ready    = 1'b0;
        push          = 1'b0;
        push_res      = '0;
        wr            = '0;
        rd_en         = 1'b0;
        rd_addr       = cur[INDEX_BITS-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                wr.en    = 1'b1;
                wr.addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (!mode)
                    begin
                        wr.en           = 1'b1;
                        wr.addr         = seq[INDEX_BITS-1:0];
                        wr.data.valid   = 1'b1;
                        wr.data.tag     = TAG_W'(seq >> INDEX_BITS);
                        wr.data.sent    = now_ms;
                        wr.data.resends = '0;
                        wr.data.ext     = ext_seq;
                        wr.data.size    = packet_size;
                        if (delta != '0 && !delta[TIME_BITS-1])
                        begin
                            latest_next = now_ms;
                        end
                    end
                    else
                    begin
                        base_next     = seq;
                        pending_next  = {lost_mask, 1'b1};
                        now_next      = now_ms;
                        held_vld_next = 1'b0;
                        state_next    = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (pending_reg != '0)
                begin
                    rd_en        = 1'b1;
                    cur_next     = cur;
                    pending_next = pending_reg & (pending_reg - 1'b1);
                    state_next   = ST_EVAL;
                end
                else if (out_free)
                begin
                    push = 1'b1;
                    if (held_vld_reg)
                    begin
                        push_res      = held_reg;
                        push_res.last = 1'b1;
                    end
                    else
                    begin
                        push_res.action = ACT_NONE;
                        push_res.seq    = base_reg;
                        push_res.last   = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_EVAL:
            begin
                if (!hit)
                begin
                    state_next = ST_ISSUE;
                end
                else if (!held_vld_reg || out_free)
                begin
                    push          = held_vld_reg;
                    push_res      = held_reg;
                    held_next     = found;
                    held_vld_next = 1'b1;
                    wr.addr       = cur_reg[INDEX_BITS-1:0];
                    wr.data       = rd_data;
                    if (is_lost)
                    begin
                        wr.en         = 1'b1;
                        wr.data.valid = 1'b0;
                    end
                    else if (!is_soon)
                    begin
                        wr.en           = 1'b1;
                        wr.data.sent    = now_reg;
                        wr.data.resends = cnt_inc;
                    end
                    state_next = ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            latest_reg   <= '0;
            pending_reg  <= '0;
            held_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            latest_reg   <= latest_next;
            pending_reg  <= pending_next;
            held_vld_reg <= held_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        now_reg  <= now_next;
        cur_reg  <= cur_next;
        held_reg <= held_next;
    end

    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed without space");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !item_ready)
        else $error("request accepted during table clear");

    a_eval_write_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && wr.en) |-> hit)
        else $error("write-back without a tag hit");

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_res.last) |=> (state_reg == ST_IDLE))
        else $error("final result did not end the walk");

    a_read_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == ST_EVAL))
        else $error("table read not followed by evaluation");

endmodule

// File: rtl/core/nack_retransmit_responder_core.sv
// Top level of the NACK retransmit responder: config registers, result register, sequencer.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  item     | item_valid/ready     | mode seq lost_mask ext_seq packet_size now_ms
//  result   | result_valid/ready   | action out_seq out_ext_seq released_bytes
//           |                      | resend_count last
//  cfg      | cfg_valid/ready      | cfg_index cfg_data
//
// A NACK request walks up to 17 numbers, seq and the set lost_mask bits, with one
// table read and one evaluation step per number; each result waits one step in a
// holding register.
// After reset all 2^INDEX_BITS (1024) table entries are cleared, one entry a cycle, while
// item_ready stays low; cfg writes are taken at any time.
// A stalled result register holds the walk at a hit with a result held, or at its end.
module nack_retransmit_responder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        mode,
    input  logic [15:0] seq,
    input  logic [15:0] lost_mask,
    input  logic [15:0] ext_seq,
    input  logic [15:0] packet_size,
    input  logic [31:0] now_ms,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  action,
    output logic [15:0] out_seq,
    output logic [15:0] out_ext_seq,
    output logic [15:0] released_bytes,
    output logic [7:0]  resend_count,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [nrr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nrr_pkg::CFG_BITS-1:0]  cfg_data
);
    import nrr_pkg::*;

    logic [CFG_BITS-1:0]   rtt_reg;
    logic [CFG_BITS-1:0]   max_delay_reg;
    logic                  out_vld_reg;
    result_t               out_reg;
    logic                  out_free;
    logic                  push;
    result_t               push_res;
    wr_t                   wr;
    logic                  rd_en;
    logic [INDEX_BITS-1:0] rd_addr;
    entry_t                rd_data;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_vld_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rtt_reg       <= DEFAULT_RTT_MS;
            max_delay_reg <= DEFAULT_MAX_DELAY_MS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RTT:       rtt_reg       <= cfg_data;
                CFG_MAX_DELAY: max_delay_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= push_res;
        end
    end

    assign result_valid   = out_vld_reg;
    assign action         = out_reg.action;
    assign out_seq        = out_reg.seq;
    assign out_ext_seq    = out_reg.ext;
    assign released_bytes = out_reg.bytes;
    assign resend_count   = out_reg.count;
    assign last           = out_reg.last;

    nrr_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .mode        (mode),
        .seq         (seq),
        .lost_mask   (lost_mask),
        .ext_seq     (ext_seq),
        .packet_size (packet_size),
        .now_ms      (now_ms),
        .rtt         (rtt_reg),
        .max_delay   (max_delay_reg),
        .out_free    (out_free),
        .push        (push),
        .push_res    (push_res),
        .wr          (wr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    nrr_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// File: bench/nack_retransmit_responder_core_test.sv
// Self-checking testbench of the NACK retransmit responder core, with its own predictor.
module nack_retransmit_responder_core_test;
    import nrr_pkg::*;

    localparam int SLOT_COUNT    = 1 << INDEX_BITS;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_PRINTED   = 40;
    localparam int RESEND_REPEAT = 16;
    localparam int BURST_COUNT   = 6;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 17;

    localparam logic MODE_STORE = 1'b0;
    localparam logic MODE_NACK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    localparam logic [CFG_BITS-1:0] PHASE_RTT [PHASES] = '{16'd40, 16'hFFFF, 16'd1, 16'd100};
    localparam logic [CFG_BITS-1:0] PHASE_AGE [PHASES] = '{16'd200, 16'hFFFF, 16'd0, 16'd3000};
    localparam int PHASE_STEP [PHASES] = '{30, 20000, 5, 60};

    typedef struct packed {
        logic        mode;
        logic [15:0] seq;
        logic [15:0] mask;
        logic [15:0] ext;
        logic [15:0] size;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] seq;
        logic [15:0] mask;
        logic [15:0] ext;
        logic [15:0] size;
        logic [31:0] now;
        logic        typed;
        logic [1:0]  act;
        logic [15:0] o_seq;
        logic [15:0] o_ext;
        logic [15:0] o_bytes;
        logic [7:0]  o_cnt;
    } row_t;

    localparam int DIR_ROWS = 22;
    localparam row_t DIR_TABLE [DIR_ROWS] = '{
        '{MODE_NACK,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000,
          TYPED, ACT_NONE, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_NACK,  16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 32'hFFFF_FFFF,
          TYPED, ACT_NONE, 16'hFFFF, 16'h0000, 16'h0000, 8'h00},
        '{MODE_STORE, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 32'h0000_0064,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_STORE, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0064,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_STORE, 16'hFFFF, 16'h0000, 16'h1234, 16'h0001, 32'h0000_0065,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_NACK,  16'hFFFF, 16'h0003, 16'h0000, 16'h0000, 32'h0000_0066,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_NACK,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0067,
          TYPED, ACT_RESEND, 16'h0000, 16'hFFFF, 16'hFFFF, 8'h01},
        '{MODE_STORE, 16'h0400, 16'h0000, 16'h0055, 16'h0066, 32'h0000_00C8,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_NACK,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_012C,
          TYPED, ACT_NONE, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_NACK,  16'h0400, 16'h0000, 16'h0000, 16'h0000, 32'h0000_012C,
          TYPED, ACT_RESEND, 16'h0400, 16'h0055, 16'h0066, 8'h01},
        '{MODE_STORE, 16'h8000, 16'h0000, 16'hAAAA, 16'h5555, 32'h0000_1388,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_NACK,  16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'h0000_1389,
          TYPED, ACT_LOST, 16'h0001, 16'h0000, 16'h0000, 8'h00},
        '{MODE_NACK,  16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'h0000_138A,
          TYPED, ACT_NONE, 16'h0001, 16'h0000, 16'h0000, 8'h00},
        '{MODE_NACK,  16'h8000, 16'h8000, 16'h0000, 16'h0000, 32'h0000_138A,
          TYPED, ACT_SOON, 16'h8000, 16'hAAAA, 16'h5555, 8'h00},
        '{MODE_STORE, 16'h0010, 16'h0000, 16'h0000, 16'h0000, 32'h8000_1387,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_STORE, 16'h0011, 16'h0000, 16'h0011, 16'h0011, 32'hFFFF_FFF0,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_STORE, 16'h0012, 16'h0000, 16'h0012, 16'h0012, 32'h0000_0010,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_STORE, 16'h0013, 16'h0000, 16'h0013, 16'h0013, 32'h8000_0010,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_NACK,  16'h0010, 16'h0007, 16'h0000, 16'h0000, 32'h0000_0020,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_NACK,  16'hFFF8, 16'hFFFF, 16'h0000, 16'h0000, 32'h0000_0021,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_STORE, 16'h03FF, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000,
          PREDICTED, ACT_RESEND, 16'h0000, 16'h0000, 16'h0000, 8'h00},
        '{MODE_NACK,  16'h03FF, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000,
          TYPED, ACT_SOON, 16'h03FF, 16'h0000, 16'h0000, 8'h00}
    };

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        item_valid     = 1'b0;
    logic        item_ready;
    logic        mode           = 1'b0;
    logic [15:0] seq            = '0;
    logic [15:0] lost_mask      = '0;
    logic [15:0] ext_seq        = '0;
    logic [15:0] packet_size    = '0;
    logic [31:0] now_ms         = '0;
    logic        result_valid;
    logic        result_ready   = 1'b0;
    logic [1:0]  action;
    logic [15:0] out_seq;
    logic [15:0] out_ext_seq;
    logic [15:0] released_bytes;
    logic [7:0]  resend_count;
    logic        last;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]  cfg_data  = '0;

    logic                  tbl_valid [SLOT_COUNT];
    logic [TAG_W-1:0]      tbl_tag   [SLOT_COUNT];
    logic [TIME_BITS-1:0]  tbl_sent  [SLOT_COUNT];
    logic [CNT_BITS-1:0]   tbl_count [SLOT_COUNT];
    logic [SEQ_BITS-1:0]   tbl_ext   [SLOT_COUNT];
    logic [SEQ_BITS-1:0]   tbl_size  [SLOT_COUNT];
    logic [TIME_BITS-1:0]  newest_send;
    logic [CFG_BITS-1:0]   cfg_rtt;
    logic [CFG_BITS-1:0]   cfg_max_age;

    result_t     pending_results [$];
    logic [15:0] stream_seq;
    logic [31:0] stream_now;
    bit          idle_en     = 1'b1;
    int          hold_asks   = 0;
    int          errors      = 0;
    int          cycle_count = 0;
    int          requests    = 0;
    int          results     = 0;
    int          cfg_writes  = 0;
    int          act_seen [4] = '{0, 0, 0, 0};

    nack_retransmit_responder_core u_dut (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch at result %0d, %s: got %0h, want %0h", results, what, got, want);
    endtask

    function automatic req_t mk_req(input logic m, input logic [15:0] s, input logic [15:0] k,
                                    input logic [15:0] e, input logic [15:0] z,
                                    input logic [31:0] t);
        req_t r;
        r.mode = m;
        r.seq  = s;
        r.mask = k;
        r.ext  = e;
        r.size = z;
        r.now  = t;
        return r;
    endfunction

    function automatic int predict_response(input req_t r);
        logic [INDEX_BITS-1:0] idx;
        logic [SEQ_BITS-1:0]   cur;
        logic [TIME_BITS-1:0]  gap;
        logic [CFG_BITS-1:0]   rtt;
        logic [CFG_BITS-1:0]   soon;
        logic [SPAN-1:0]       walk;
        result_t               res;
        result_t               held;
        bit                    have;
        int                    n;
        n    = 0;
        have = 1'b0;
        if (r.mode == MODE_STORE) begin
            idx            = r.seq[INDEX_BITS-1:0];
            tbl_valid[idx] = 1'b1;
            tbl_tag[idx]   = r.seq[SEQ_BITS-1:INDEX_BITS];
            tbl_sent[idx]  = r.now;
            tbl_count[idx] = '0;
            tbl_ext[idx]   = r.ext;
            tbl_size[idx]  = r.size;
            gap = r.now - newest_send;
            if (gap != '0 && !gap[TIME_BITS-1])
                newest_send = r.now;
            return 0;
        end
        rtt  = (cfg_rtt != '0) ? cfg_rtt : DEFAULT_RTT_MS;
        soon = rtt >> RTT_SHIFT;
        walk = {r.mask, 1'b1};
        for (int i = 0; i < SPAN; i++) begin
            cur = r.seq + SEQ_BITS'(i);
            idx = cur[INDEX_BITS-1:0];
            if (walk[i] && tbl_valid[idx] && tbl_tag[idx] == cur[SEQ_BITS-1:INDEX_BITS])
            begin
                res.seq   = cur;
                res.ext   = tbl_ext[idx];
                res.bytes = tbl_size[idx];
                res.last  = 1'b0;
                if (newest_send - tbl_sent[idx] > TIME_BITS'(cfg_max_age)) begin
                    res.action     = ACT_LOST;
                    res.count      = tbl_count[idx];
                    tbl_valid[idx] = 1'b0;
                end
                else if (r.now - tbl_sent[idx] <= TIME_BITS'(soon)) begin
                    res.action = ACT_SOON;
                    res.count  = tbl_count[idx];
                end
                else begin
                    tbl_sent[idx] = r.now;
                    if (tbl_count[idx] != '1)
                        tbl_count[idx]++;
                    res.action = ACT_RESEND;
                    res.count  = tbl_count[idx];
                end
                if (have)
                    pending_results = {pending_results, held};
                held = res;
                have = 1'b1;
                n++;
            end
        end
        if (!have) begin
            held = '{ACT_NONE, r.seq, '0, '0, '0, 1'b0};
            n    = 1;
        end
        held.last = 1'b1;
        pending_results = {pending_results, held};
        return n;
    endfunction

    task automatic send_request(input req_t r, input bit typed = PREDICTED,
                                input result_t want = '0);
        int n;
        while (idle_en && $urandom_range(99) < 36) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        mode        <= r.mode;
        seq         <= r.seq;
        lost_mask   <= r.mask;
        ext_seq     <= r.ext;
        packet_size <= r.size;
        now_ms      <= r.now;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        n = predict_response(r);
        if (typed) begin
            repeat (n) void'(pending_results.pop_back());
            pending_results = {pending_results, want};
        end
        requests++;
    endtask

    task automatic configure(input logic [CFG_BITS-1:0] rtt, input logic [CFG_BITS-1:0] age,
                             input logic [CFG_IDX_W-1:0] spare);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [CFG_BITS-1:0]  val [3];
        idx = '{CFG_RTT, CFG_MAX_DELAY, spare};
        val = '{rtt, age, 16'($urandom)};
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (idx[k] == CFG_RTT)
                cfg_rtt = val[k];
            else if (idx[k] == CFG_MAX_DELAY)
                cfg_max_age = val[k];
            cfg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_traffic(input int count, input int tstep);
        req_t r;
        int   pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 5)
                stream_now += $urandom_range(70000);
            stream_now += $urandom_range(tstep);
            r = mk_req(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), $urandom);
            if (pick < 45) begin
                r.mode = MODE_STORE;
                r.now  = stream_now;
                if ($urandom_range(9) == 0)
                    r.seq = stream_seq ^ (16'($urandom_range(63, 1)) << INDEX_BITS);
                else begin
                    r.seq = stream_seq;
                    stream_seq++;
                end
            end
            else if (pick < 85) begin
                r.mode = MODE_NACK;
                r.now  = stream_now;
                r.seq  = stream_seq - 16'($urandom_range(20, 1));
            end
            send_request(r);
        end
    endtask

    task automatic check_result();
        result_t want;
        results++;
        act_seen[action]++;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending, out_seq", 32'(out_seq), '0);
            return;
        end
        want = pending_results.pop_front();
        if (action !== want.action)
            report_mismatch("action", 32'(action), 32'(want.action));
        if (out_seq !== want.seq)
            report_mismatch("out_seq", 32'(out_seq), 32'(want.seq));
        if (out_ext_seq !== want.ext)
            report_mismatch("out_ext_seq", 32'(out_ext_seq), 32'(want.ext));
        if (released_bytes !== want.bytes)
            report_mismatch("released_bytes", 32'(released_bytes), 32'(want.bytes));
        if (resend_count !== want.count)
            report_mismatch("resend_count", 32'(resend_count), 32'(want.count));
        if (last !== want.last)
            report_mismatch("last", 32'(last), 32'(want.last));
    endtask

    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready)
            check_result();
    end

    initial begin : receiver
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_asks != holds_seen) begin
                holds_seen = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (!idle_en)
                result_ready <= 1'b1;
            else
                result_ready <= ($urandom_range(99) >= 36);
        end
    end

    initial begin : stimulus
        row_t        row;
        result_t     want;
        logic [31:0] t0;
        for (int k = 0; k < SLOT_COUNT; k++)
            tbl_valid[k] = 1'b0;
        newest_send = '0;
        cfg_rtt     = DEFAULT_RTT_MS;
        cfg_max_age = DEFAULT_MAX_DELAY_MS;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero rtt falls back to the default
        configure(16'd0, DEFAULT_MAX_DELAY_MS, CFG_UNUSED_2);
        for (int k = 0; k < DIR_ROWS; k++) begin
            row  = DIR_TABLE[k];
            want = '{row.act, row.o_seq, row.o_ext, row.o_bytes, row.o_cnt, 1'b1};
            send_request(mk_req(row.mode, row.seq, row.mask, row.ext, row.size, row.now),
                         row.typed, want);
        end
        settle();

        // resend one packet again and again, no idling on either side
        configure(16'd4, 16'hFFFF, CFG_UNUSED_3);
        idle_en = 1'b0;
        t0 = newest_send + 32'd100;
        send_request(mk_req(MODE_STORE, 16'h2222, '0, 16'h0BAD, 16'h0100, t0));
        send_request(mk_req(MODE_STORE, 16'h2230, '0, 16'h0000, 16'h0040, t0 + 32'd1000));
        for (int k = 0; k < RESEND_REPEAT; k++)
            send_request(mk_req(MODE_NACK, 16'h2222, '0, '0, '0, t0 + 32'(2 * (k + 1))));
        idle_en = 1'b1;

        // hold the output while full-span NACKs keep coming
        t0 = newest_send + 32'd10;
        for (int k = 0; k < SPAN; k++)
            send_request(mk_req(MODE_STORE, 16'h3000 + 16'(k), '0, 16'(k + 7), 16'(k * 3),
                                t0 + 32'(k)));
        send_request(mk_req(MODE_STORE, 16'h3100, '0, '0, '0, t0 + 32'd2000));
        hold_asks++;
        for (int k = 0; k < BURST_COUNT; k++)
            send_request(mk_req(MODE_NACK, 16'h3000, 16'hFFFF, '0, '0,
                                t0 + 32'(100 * (k + 1))));
        settle();

        for (int p = 0; p < PHASES; p++) begin
            configure(PHASE_RTT[p], PHASE_AGE[p], (p % 2) ? CFG_UNUSED_2 : CFG_UNUSED_3);
            stream_seq = 16'($urandom);
            stream_now = newest_send + 32'd1;
            run_traffic(PHASE_ITEMS, PHASE_STEP[p]);
            settle();
        end

        $display("covered %0d requests (%0d from the table), %0d config writes, %0d cycles",
                 requests, DIR_ROWS, cfg_writes, cycle_count);
        $display("results checked: %0d resend, %0d lost, %0d too soon, %0d none found",
                 act_seen[ACT_RESEND], act_seen[ACT_LOST], act_seen[ACT_SOON],
                 act_seen[ACT_NONE]);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
